>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the list engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, codes and types of the circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int POOL_SIZE_DEF = 16;
   localparam int DATA_W        = 32;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DELETE  = 2'd1;
   localparam logic [1:0] OP_DISPLAY = 2'd2;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_EMPTY     = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WR_FIRST,
      S_FIND,
      S_TAIL,
      S_WR_LINK,
      S_DISP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } res_type;

endpackage

>>> sv/circular_list_engine_core.sv
// Insert walks the ring to the anchor node, then writes the new node and relinks the anchor;
//   an absent anchor gives STS_NOT_FOUND, an empty list takes the first node, a full pool STS_FULL.
// Delete: walks to the match, the front needs a tail walk; absent gives STS_NOT_FOUND, empty STS_EMPTY.
// Display: one value per cycle while the output register can take it (one read a cycle).
// Next request taken in the idle state after the last result loads.
// Reset (synchronous) empties the list and frees every node.
// ----------------------------------------------------------------------------
// circular_list_engine_core
// Circular singly linked list of signed words in a fixed node pool.
// ----------------------------------------------------------------------------
module circular_list_engine_core import cle_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*DATA_W-1:0] req_tdata,   // [31:0] item_value, [63:32] anchor_value
   input  logic [1:0]          req_tuser,   // [1:0] opcode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [31:0] out_value
   output logic [1:0]          rsp_tuser,   // [1:0] status
   output logic                rsp_tlast    // last
);

   localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

   logic                     pool_full;
   logic [IW-1:0]            pool_free_idx;
   logic                     pool_set_en;
   logic [IW-1:0]            pool_set_idx;
   logic                     pool_clr_en;
   logic [IW-1:0]            pool_clr_idx;
   logic [IW-1:0]            rd_addr;
   logic signed [DATA_W-1:0] rd_value;
   logic [IW-1:0]            rd_next;
   logic                     wr_value_en;
   logic                     wr_next_en;
   logic [IW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_value;
   logic [IW-1:0]            wr_next;
   logic                     res_free;
   logic                     res_load;
   res_type                  res;

   logic                     out_valid_ff, out_valid_in;
   res_type                  out_res_ff, out_res_in;

   cle_ctrl #(.POOL_SIZE(POOL_SIZE), .IW(IW)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_op        (req_tuser),
      .req_item      ($signed(req_tdata[DATA_W-1:0])),
      .req_anchor    ($signed(req_tdata[2*DATA_W-1:DATA_W])),
      .pool_full     (pool_full),
      .pool_free_idx (pool_free_idx),
      .pool_set_en   (pool_set_en),
      .pool_set_idx  (pool_set_idx),
      .pool_clr_en   (pool_clr_en),
      .pool_clr_idx  (pool_clr_idx),
      .rd_addr       (rd_addr),
      .rd_value      (rd_value),
      .rd_next       (rd_next),
      .wr_value_en   (wr_value_en),
      .wr_next_en    (wr_next_en),
      .wr_addr       (wr_addr),
      .wr_value      (wr_value),
      .wr_next       (wr_next),
      .res_free      (res_free),
      .res_load      (res_load),
      .res           (res)
   );

   cle_node_mem #(.POOL_SIZE(POOL_SIZE), .IW(IW)) u_node_mem (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .rd_value    (rd_value),
      .rd_next     (rd_next),
      .wr_value_en (wr_value_en),
      .wr_next_en  (wr_next_en),
      .wr_addr     (wr_addr),
      .wr_value    (wr_value),
      .wr_next     (wr_next)
   );

   cle_free_pool #(.POOL_SIZE(POOL_SIZE), .IW(IW)) u_free_pool (
      .clock    (clock),
      .reset    (reset),
      .set_en   (pool_set_en),
      .set_idx  (pool_set_idx),
      .clr_en   (pool_clr_en),
      .clr_idx  (pool_clr_idx),
      .full     (pool_full),
      .free_idx (pool_free_idx)
   );

   // output register: refilled in the same cycle it is drained
   assign res_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (res_load) begin
         out_valid_in = 1'b1;
         out_res_in   = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.value;
   assign rsp_tuser  = out_res_ff.status;
   assign rsp_tlast  = out_res_ff.last;

endmodule

>>> sv/cle_node_mem.sv
// ----------------------------------------------------------------------------
// cle_node_mem
// Node store: value and link per pool entry, one write and one registered read.
// ----------------------------------------------------------------------------
module cle_node_mem import cle_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF,
   parameter int IW        = $clog2(POOL_SIZE)
) (
   input  logic                     clock,
   input  logic [IW-1:0]            rd_addr,
   output logic signed [DATA_W-1:0] rd_value,
   output logic [IW-1:0]            rd_next,
   input  logic                     wr_value_en,
   input  logic                     wr_next_en,
   input  logic [IW-1:0]            wr_addr,
   input  logic signed [DATA_W-1:0] wr_value,
   input  logic [IW-1:0]            wr_next
);

   logic signed [DATA_W-1:0] value_mem [POOL_SIZE];
   logic [IW-1:0]            next_mem  [POOL_SIZE];
   logic signed [DATA_W-1:0] rd_value_ff;
   logic [IW-1:0]            rd_next_ff;

   always_ff @(posedge clock) begin
      if (wr_value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_next_en) begin
         next_mem[wr_addr] <= wr_next;
      end
      rd_value_ff <= value_mem[rd_addr];
      rd_next_ff  <= next_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;

endmodule

>>> sv/cle_free_pool.sv
// ----------------------------------------------------------------------------
// cle_free_pool
// Occupancy bits of the node pool and lowest-free-entry selection.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_free_pool import cle_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF,
   parameter int IW        = $clog2(POOL_SIZE)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          set_en,
   input  logic [IW-1:0] set_idx,
   input  logic          clr_en,
   input  logic [IW-1:0] clr_idx,
   output logic          full,
   output logic [IW-1:0] free_idx
);

   logic [POOL_SIZE-1:0] used_ff;
   logic [POOL_SIZE-1:0] used_in;

   always_comb begin
      used_in = used_ff;
      if (set_en) begin
         used_in[set_idx] = 1'b1;
      end
      if (clr_en) begin
         used_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // lowest free entry wins
   always_comb begin
      free_idx = '0;
      for (int i = POOL_SIZE - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign full = &used_ff;

   `CLE_ASSERT(a_set_free, set_en |-> !used_ff[set_idx], "allocating a node already in use")
   `CLE_ASSERT(a_clr_used, clr_en |-> used_ff[clr_idx], "releasing a node not in use")

endmodule

>>> sv/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer: walks the ring one node per cycle unless the output stalls a display;
// searches use the shared comparator; issues the link updates for insert and delete.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_ctrl import cle_pkg::*; #(
   parameter int POOL_SIZE = POOL_SIZE_DEF,
   parameter int IW        = $clog2(POOL_SIZE)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_op,
   input  logic signed [DATA_W-1:0] req_item,
   input  logic signed [DATA_W-1:0] req_anchor,
   input  logic                     pool_full,
   input  logic [IW-1:0]            pool_free_idx,
   output logic                     pool_set_en,
   output logic [IW-1:0]            pool_set_idx,
   output logic                     pool_clr_en,
   output logic [IW-1:0]            pool_clr_idx,
   output logic [IW-1:0]            rd_addr,
   input  logic signed [DATA_W-1:0] rd_value,
   input  logic [IW-1:0]            rd_next,
   output logic                     wr_value_en,
   output logic                     wr_next_en,
   output logic [IW-1:0]            wr_addr,
   output logic signed [DATA_W-1:0] wr_value,
   output logic [IW-1:0]            wr_next,
   input  logic                     res_free,
   output logic                     res_load,
   output res_type                  res
);

   state_type                state_ff, state_in;
   logic [1:0]               op_ff, op_in;
   logic signed [DATA_W-1:0] item_ff, item_in;
   logic signed [DATA_W-1:0] anchor_ff, anchor_in;
   logic [1:0]               sts_ff, sts_in;
   logic [IW-1:0]            cur_ff, cur_in;
   logic [IW-1:0]            prev_ff, prev_in;
   logic [IW-1:0]            new_ff, new_in;
   logic [IW-1:0]            nx_ff, nx_in;
   logic [IW-1:0]            front_ff, front_in;
   logic                     empty_ff, empty_in;

   logic                     key_match;
   logic                     next_is_front;

   // the one comparator every search goes through (insert and delete)
   assign key_match     = (rd_value == ((op_ff == OP_INSERT) ? anchor_ff : item_ff));
   assign next_is_front = (rd_next == front_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         empty_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      item_ff   <= item_in;
      anchor_ff <= anchor_in;
      sts_ff    <= sts_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      new_ff    <= new_in;
      nx_ff     <= nx_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      anchor_in    = anchor_ff;
      sts_in       = sts_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      new_in       = new_ff;
      nx_in        = nx_ff;
      front_in     = front_ff;
      empty_in     = empty_ff;
      req_ready    = 1'b0;
      rd_addr      = cur_ff;
      wr_value_en  = 1'b0;
      wr_next_en   = 1'b0;
      wr_addr      = cur_ff;
      wr_value     = item_ff;
      wr_next      = rd_next;
      pool_set_en  = 1'b0;
      pool_set_idx = new_ff;
      pool_clr_en  = 1'b0;
      pool_clr_idx = cur_ff;
      res_load     = 1'b0;
      res.status   = sts_ff;
      res.value    = '0;
      res.last     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = front_ff;
            if (req_valid) begin
               op_in     = req_op;
               item_in   = req_item;
               anchor_in = req_anchor;
               cur_in    = front_ff;
               prev_in   = front_ff;
               new_in    = pool_free_idx;
               case (req_op)
                  OP_INSERT: begin
                     if (pool_full) begin
                        sts_in   = STS_FULL;
                        state_in = S_RESP;
                     end else if (empty_ff) begin
                        state_in = S_WR_FIRST;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  OP_DELETE: begin
                     if (empty_ff) begin
                        sts_in   = STS_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  OP_DISPLAY: begin
                     if (empty_ff) begin
                        sts_in   = STS_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DISP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_WR_FIRST: begin
            wr_value_en = 1'b1;
            wr_next_en  = 1'b1;
            wr_addr     = new_ff;
            wr_next     = new_ff;
            pool_set_en = 1'b1;
            front_in    = new_ff;
            empty_in    = 1'b0;
            sts_in      = STS_OK;
            state_in    = S_RESP;
         end

         S_FIND: begin
            if (key_match) begin
               if (op_ff == OP_INSERT) begin
                  // new node inherits the anchor's link
                  wr_value_en = 1'b1;
                  wr_next_en  = 1'b1;
                  wr_addr     = new_ff;
                  state_in    = S_WR_LINK;
               end else if (cur_ff == front_ff) begin
                  if (rd_next == cur_ff) begin
                     pool_clr_en = 1'b1;
                     empty_in    = 1'b1;
                     front_in    = '0;
                     sts_in      = STS_OK;
                     state_in    = S_RESP;
                  end else begin
                     // front goes: find the tail to close the ring
                     nx_in    = rd_next;
                     cur_in   = rd_next;
                     rd_addr  = rd_next;
                     state_in = S_TAIL;
                  end
               end else begin
                  wr_next_en  = 1'b1;
                  wr_addr     = prev_ff;
                  pool_clr_en = 1'b1;
                  sts_in      = STS_OK;
                  state_in    = S_RESP;
               end
            end else if (next_is_front) begin
               sts_in   = STS_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_next;
               rd_addr = rd_next;
            end
         end

         S_TAIL: begin
            if (next_is_front) begin
               wr_next_en   = 1'b1;
               wr_next      = nx_ff;
               pool_clr_en  = 1'b1;
               pool_clr_idx = front_ff;
               front_in     = nx_ff;
               sts_in       = STS_OK;
               state_in     = S_RESP;
            end else begin
               cur_in  = rd_next;
               rd_addr = rd_next;
            end
         end

         S_WR_LINK: begin
            wr_next_en  = 1'b1;
            wr_next     = new_ff;
            pool_set_en = 1'b1;
            sts_in      = STS_OK;
            state_in    = S_RESP;
         end

         S_DISP: begin
            res.status = STS_OK;
            res.value  = rd_value;
            res.last   = next_is_front;
            // read port stays on the current node while the output is busy
            if (res_free) begin
               res_load = 1'b1;
               if (next_is_front) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in  = rd_next;
                  rd_addr = rd_next;
               end
            end
         end

         S_RESP: begin
            if (res_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `CLE_ASSERT(a_empty_front, empty_ff |-> (front_ff == '0), "empty list with non-zero front")
   `CLE_ASSERT_NEXT(a_disp_end, (state_ff == S_DISP) && res_load && res.last, (state_ff == S_IDLE), "display did not finish after its last request")

endmodule
